### rtl/core/bfla_pkg.sv
`default_nettype none

package bfla_pkg;

  // field widths
  localparam int BNO_W   = 12;
  localparam int GRANT_W = 13;
  localparam int STAT_W  = 2;
  localparam int ACT_W   = 2;
  localparam int OP_W    = 3;

  // pool size after reset
  localparam logic [GRANT_W-1:0] POOL_RESET = 13'd4096;

  // request actions
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEED  = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

  // classified operations handed from front to back
  localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
  localparam logic [OP_W-1:0] OP_SEED_FREE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEED_USED = 3'd4;
  localparam logic [OP_W-1:0] OP_RANGE     = 3'd5;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QA_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BNO_W-1:0] bno;
  } item_t;

endpackage

`default_nettype wire

### rtl/core/bfla_ifs.sv
`default_nettype none

// request channel
interface bfla_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfla_pkg::ACT_W-1:0]  action;
  logic [bfla_pkg::BNO_W-1:0]  block_number;
  logic                        block_used;

  modport source (output valid, action, block_number, block_used, input ready);
  modport sink   (input valid, action, block_number, block_used, output ready);
endinterface

// result channel
interface bfla_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfla_pkg::GRANT_W-1:0]  granted_block;
  logic [bfla_pkg::STAT_W-1:0]   status;

  modport source (output valid, granted_block, status, input ready);
  modport sink   (input valid, granted_block, status, output ready);
endinterface

// configuration write channel
interface bfla_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfla_pkg::GRANT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/block_free_list_allocator.sv
// Block allocator over a pool of MAX_BLOCKS storage blocks.
// req: one beat per request (action, block_number, block_used). Allocate pops
//   the head of the free list, free pushes at the head, seed appends an unused
//   block at the tail. Every request gives exactly one rsp beat
//   (granted_block, status) in request order.
// cfg: one beat writes pool_blocks; ready is always high. Write it only while
//   no request is in flight.
// Path: an accepted request is written to the queue, fetched by the back end,
//   executed once the result register is free, and held there as rsp.valid.
// The back end takes a new request only after the last one has finished both
//   its fetch (flag memory and ring head read) and its update.
// A 2-beat queue sits between the request decoder and the back end, so
//   requests keep being taken while a result waits; when rsp stalls, the back
//   end holds its operation and the queue fills, then req.ready drops.
// Reset: the free flags, min(MAX_BLOCKS, 4096) entries, are cleared one entry a
//   cycle with req.ready low; cfg writes are taken meanwhile. pool_blocks
//   resets to 4096, the free list to empty.
`default_nettype none

module block_free_list_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input wire logic    clk,
  input wire logic    rst,
  bfla_req_if.sink    req,
  bfla_rsp_if.source  rsp,
  bfla_cfg_if.sink    cfg
);

  logic                          clearing;
  logic                          push_valid;
  logic                          push_ready;
  bfla_pkg::item_t               push_item;
  logic                          pop_valid;
  logic                          pop_ready;
  bfla_pkg::item_t               pop_item;
  logic [bfla_pkg::GRANT_W-1:0]  pool_blocks;

  // decode and range check
  bfla_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cfg         (cfg),
    .clearing    (clearing),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item),
    .pool_blocks (pool_blocks)
  );

  // decoupling queue
  bfla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // flag memory, free ring and result register
  bfla_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .pool_blocks (pool_blocks),
    .clearing    (clearing),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

### rtl/core/bfla_front.sv
`default_nettype none

module bfla_front #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  bfla_req_if.sink                           req,
  bfla_cfg_if.sink                           cfg,
  input  wire logic                          clearing,
  output      logic                          push_valid,
  input  wire logic                          push_ready,
  output      bfla_pkg::item_t               push_item,
  output      logic [bfla_pkg::GRANT_W-1:0]  pool_blocks
);

  logic in_pool;

  // pool size register, written any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= bfla_pkg::POOL_RESET;
    end else if (cfg.valid) begin
      pool_blocks <= cfg.data;
    end
  end

  // hold requests while the flag memory is being cleared
  assign req.ready  = push_ready && !clearing;
  assign push_valid = req.valid && !clearing;

  // range check and decode
  assign in_pool = ({1'b0, req.block_number} < pool_blocks) &&
                   (32'(req.block_number) < 32'(MAX_BLOCKS));

  always_comb begin
    push_item.bno = req.block_number;
    case (req.action)
      bfla_pkg::ACT_ALLOC: push_item.op = bfla_pkg::OP_ALLOC;
      bfla_pkg::ACT_FREE: begin
        push_item.op = in_pool ? bfla_pkg::OP_FREE : bfla_pkg::OP_RANGE;
      end
      bfla_pkg::ACT_SEED: begin
        if (!in_pool) begin
          push_item.op = bfla_pkg::OP_RANGE;
        end else if (req.block_used) begin
          push_item.op = bfla_pkg::OP_SEED_USED;
        end else begin
          push_item.op = bfla_pkg::OP_SEED_FREE;
        end
      end
      default: push_item.op = bfla_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bfla_queue.sv
`default_nettype none

module bfla_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire bfla_pkg::item_t  push_item,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      bfla_pkg::item_t  pop_item
);

  bfla_pkg::item_t                entries [bfla_pkg::Q_DEPTH];
  logic [bfla_pkg::QA_W-1:0]      wr_ptr;
  logic [bfla_pkg::QA_W-1:0]      rd_ptr;
  logic [bfla_pkg::QC_W-1:0]      fill;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (fill != bfla_pkg::QC_W'(bfla_pkg::Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

### rtl/core/bfla_back.sv
`default_nettype none

module bfla_back #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output      logic                          pop_ready,
  input  wire bfla_pkg::item_t               pop_item,
  input  wire logic [bfla_pkg::GRANT_W-1:0]  pool_blocks,
  output      logic                          clearing,
  bfla_rsp_if.source                         rsp
);

  // block numbers are 12 bits, so flags never need more than 4096 entries
  localparam int FLAG_N  = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
  localparam int FLAG_AW = $clog2(FLAG_N);
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]                    state;
  logic [FLAG_AW-1:0]            clr_addr;

  logic                          flags [FLAG_N];
  logic [bfla_pkg::BNO_W-1:0]    ring  [MAX_BLOCKS];

  logic [IDX_W-1:0]              ring_head;
  logic [IDX_W-1:0]              ring_tail;
  logic [CNT_W-1:0]              free_count;

  bfla_pkg::item_t               cur;
  logic                          flag_rd;
  logic [bfla_pkg::BNO_W-1:0]    ring_rd;

  logic                          out_valid;
  logic [bfla_pkg::GRANT_W-1:0]  out_grant;
  logic [bfla_pkg::STAT_W-1:0]   out_status;

  logic                          go;
  logic                          fw_en;
  logic [FLAG_AW-1:0]            fw_addr;
  logic                          fw_val;
  logic                          rw_en;
  logic [IDX_W-1:0]              rw_addr;
  logic [IDX_W-1:0]              head_inc;
  logic [IDX_W-1:0]              head_dec;
  logic [IDX_W-1:0]              tail_inc;
  logic [IDX_W-1:0]              head_next;
  logic [IDX_W-1:0]              tail_next;
  logic [CNT_W-1:0]              count_next;
  logic                          has_room;
  logic [bfla_pkg::GRANT_W-1:0]  res_grant;
  logic [bfla_pkg::STAT_W-1:0]   res_status;

  assign clearing  = (state == S_CLEAR);
  assign pop_ready = (state == S_IDLE);
  assign go        = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign rsp.valid         = out_valid;
  assign rsp.granted_block = out_grant;
  assign rsp.status        = out_status;

  // ring pointer wrap
  assign head_inc = (ring_head == IDX_W'(MAX_BLOCKS - 1)) ? '0 : ring_head + 1'b1;
  assign head_dec = (ring_head == '0) ? IDX_W'(MAX_BLOCKS - 1) : ring_head - 1'b1;
  assign tail_inc = (ring_tail == IDX_W'(MAX_BLOCKS - 1)) ? '0 : ring_tail + 1'b1;
  assign has_room = (free_count < CNT_W'(MAX_BLOCKS));

  // execute one operation from the fetched flag and head entry
  always_comb begin
    fw_en      = 1'b0;
    fw_addr    = cur.bno[FLAG_AW-1:0];
    fw_val     = 1'b1;
    rw_en      = 1'b0;
    rw_addr    = ring_tail;
    head_next  = ring_head;
    tail_next  = ring_tail;
    count_next = free_count;
    res_grant  = '0;
    res_status = bfla_pkg::ST_OK;
    case (cur.op)
      bfla_pkg::OP_ALLOC: begin
        if (free_count == '0) begin
          res_grant  = pool_blocks;
          res_status = bfla_pkg::ST_EMPTY;
        end else begin
          res_grant  = {1'b0, ring_rd};
          fw_en      = 1'b1;
          fw_addr    = ring_rd[FLAG_AW-1:0];
          fw_val     = 1'b0;
          head_next  = head_inc;
          count_next = free_count - 1'b1;
        end
      end
      bfla_pkg::OP_FREE: begin
        if (flag_rd) begin
          res_status = bfla_pkg::ST_DOUBLE;
        end else if (has_room) begin
          fw_en      = 1'b1;
          rw_en      = 1'b1;
          rw_addr    = head_dec;
          head_next  = head_dec;
          count_next = free_count + 1'b1;
        end
      end
      bfla_pkg::OP_SEED_FREE: begin
        if (flag_rd) begin
          res_status = bfla_pkg::ST_DOUBLE;
        end else if (has_room) begin
          fw_en      = 1'b1;
          rw_en      = 1'b1;
          rw_addr    = ring_tail;
          tail_next  = tail_inc;
          count_next = free_count + 1'b1;
        end
      end
      bfla_pkg::OP_SEED_USED: begin
        if (flag_rd) res_status = bfla_pkg::ST_DOUBLE;
      end
      bfla_pkg::OP_RANGE: res_status = bfla_pkg::ST_RANGE;
      default: begin
        res_status = bfla_pkg::ST_OK;
      end
    endcase
  end

  // sequencer, ring pointers, result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      ring_head  <= '0;
      ring_tail  <= '0;
      free_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == FLAG_AW'(FLAG_N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            ring_head  <= head_next;
            ring_tail  <= tail_next;
            free_count <= count_next;
            state      <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // fetch stage: latch item and read both memories
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur     <= pop_item;
      flag_rd <= flags[pop_item.bno[FLAG_AW-1:0]];
      ring_rd <= ring[ring_head];
    end
  end

  // flag memory write port: clearing pass or update
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      flags[clr_addr] <= 1'b0;
    end else if (go && fw_en) begin
      flags[fw_addr] <= fw_val;
    end
  end

  // ring memory write port
  always_ff @(posedge clk) begin
    if (go && rw_en) ring[rw_addr] <= cur.bno;
  end

  // result register
  always_ff @(posedge clk) begin
    if (go) begin
      out_grant  <= res_grant;
      out_status <= res_status;
    end
  end

endmodule

`default_nettype wire

### test/block_free_list_allocator_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and pool-size channels of the allocator, keeps
// its own copy of the free list and flags, and compares every result beat
// with the oldest predicted grant.
module block_free_list_allocator_checker (
  input  logic       clk,
  input  logic       rst,
  bfla_req_if        req,
  bfla_rsp_if        rsp,
  bfla_cfg_if        cfg,
  output int         fail_count,
  output int         outstanding
);

  localparam int POOL_DEPTH = 4096;

  typedef struct packed {
    logic [bfla_pkg::GRANT_W-1:0] granted_block;
    logic [bfla_pkg::STAT_W-1:0]  status;
  } grant_t;

  // shadow allocator state
  logic [bfla_pkg::GRANT_W-1:0] pool_blocks;
  bit                           free_flag [POOL_DEPTH];
  logic [bfla_pkg::BNO_W-1:0]   free_ring [POOL_DEPTH];
  logic [bfla_pkg::BNO_W-1:0]   ring_head;
  logic [bfla_pkg::BNO_W-1:0]   ring_tail;
  int                           free_count;
  grant_t                       grant_q [$];

  initial fail_count = 0;

  // Applies one request to the shadow state and returns its grant.
  function automatic grant_t predict_grant(input logic [bfla_pkg::ACT_W-1:0] act,
                                           input logic [bfla_pkg::BNO_W-1:0] bno,
                                           input logic used);
    grant_t                     g;
    logic [bfla_pkg::BNO_W-1:0] b;
    logic                       in_pool;
    g.granted_block = '0;
    g.status        = bfla_pkg::ST_OK;
    in_pool         = {1'b0, bno} < pool_blocks;
    case (act)
      bfla_pkg::ACT_ALLOC: begin
        if (free_count == 0) begin
          g.granted_block = pool_blocks;
          g.status        = bfla_pkg::ST_EMPTY;
        end else begin
          // head entry is granted even if the pool has shrunk below it
          b               = free_ring[ring_head];
          free_flag[b]    = 1'b0;
          ring_head       = ring_head + 1'b1;
          free_count--;
          g.granted_block = {1'b0, b};
        end
      end
      bfla_pkg::ACT_FREE: begin
        if (!in_pool) begin
          g.status = bfla_pkg::ST_RANGE;
        end else if (free_flag[bno]) begin
          g.status = bfla_pkg::ST_DOUBLE;
        end else if (free_count < POOL_DEPTH) begin
          free_flag[bno]       = 1'b1;
          ring_head            = ring_head - 1'b1;
          free_ring[ring_head] = bno;
          free_count++;
        end
      end
      bfla_pkg::ACT_SEED: begin
        if (!in_pool) begin
          g.status = bfla_pkg::ST_RANGE;
        end else if (free_flag[bno]) begin
          g.status = bfla_pkg::ST_DOUBLE;
        end else if (!used && free_count < POOL_DEPTH) begin
          free_flag[bno]       = 1'b1;
          free_ring[ring_tail] = bno;
          ring_tail            = ring_tail + 1'b1;
          free_count++;
        end
      end
      default: begin
        // unknown action: no change, zero result
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      pool_blocks = bfla_pkg::POOL_RESET;
      for (int i = 0; i < POOL_DEPTH; i++) free_flag[i] = 1'b0;
      ring_head  = '0;
      ring_tail  = '0;
      free_count = 0;
      grant_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) pool_blocks = cfg.data;

      // result beat against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got.granted_block = rsp.granted_block;
        got.status        = rsp.status;
        if (grant_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: granted_block %0d status %0d",
                   $time, got.granted_block, got.status);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (got.granted_block !== want.granted_block) begin
            $display("%0t: granted_block expected %0d, got %0d",
                     $time, want.granted_block, got.granted_block);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
        end
      end

      if (req.valid && req.ready)
        grant_q.insert(grant_q.size(),
                       predict_grant(req.action, req.block_number, req.block_used));
    end
    outstanding = grant_q.size();
  end

endmodule

### test/block_free_list_allocator_test.sv
`timescale 1ns / 100ps

// Drives seed, allocate and free requests into the allocator under several
// idle and stall mixes; the checker predicts and compares the grants.
module block_free_list_allocator_test;

  localparam logic [bfla_pkg::ACT_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   idle_pct;
  int   stall_pct;

  bfla_req_if req ();
  bfla_rsp_if rsp ();
  bfla_cfg_if cfg ();

  block_free_list_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  block_free_list_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result back-pressure
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_free_list_allocator test failed");
      $finish;
    end
  end

  // One request beat, with random idle cycles ahead of it.
  task automatic send_request(input logic [bfla_pkg::ACT_W-1:0] act, input int bno,
                              input bit used);
    while ($urandom_range(0, 99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.block_number <= bno[bfla_pkg::BNO_W-1:0];
    req.block_used   <= used;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Pool size write once every grant has come back.
  task automatic write_pool(input int blocks);
    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= blocks[bfla_pkg::GRANT_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Ascending seed pass over up to 48 blocks of the pool, then mostly allocate and free
  // traffic on the seeded blocks, with some noise.
  task automatic run_phase(input int pool_size, input int sender_idle, input int rcv_stall,
                           input int n_items);
    int n_seed;
    int first;
    int pick;
    write_pool(pool_size);
    idle_pct  = sender_idle;
    stall_pct = rcv_stall;
    n_seed    = (pool_size < 48) ? pool_size : 48;
    first     = $urandom_range(0, pool_size - n_seed);
    for (int i = 0; i < n_seed; i++)
      send_request(bfla_pkg::ACT_SEED, first + i, $urandom_range(0, 99) < 30);
    for (int i = n_seed; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)
        send_request(bfla_pkg::ACT_ALLOC, $urandom_range(0, 4095),
                     1'($urandom_range(0, 1)));
      else if (pick < 80)
        send_request(bfla_pkg::ACT_FREE, $urandom_range(first, first + n_seed - 1),
                     1'($urandom_range(0, 1)));
      else if (pick < 87)
        send_request(bfla_pkg::ACT_SEED, $urandom_range(0, pool_size - 1),
                     1'($urandom_range(0, 1)));
      else
        send_request(bfla_pkg::ACT_W'($urandom_range(0, 3)), $urandom_range(0, 4095),
                     1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst              = 1'b1;
    cycle_count      = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    req.valid        = 1'b0;
    req.action       = bfla_pkg::ACT_ALLOC;
    req.block_number = '0;
    req.block_used   = 1'b0;
    rsp.ready        = 1'b0;
    cfg.valid        = 1'b0;
    cfg.data         = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: reset pool size, empty list, double free, seeds, unknown action
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_FREE, 4095, 1'b0);
    send_request(bfla_pkg::ACT_FREE, 4095, 1'b1);
    send_request(bfla_pkg::ACT_ALLOC, 4095, 1'b1);
    send_request(bfla_pkg::ACT_SEED, 0, 1'b0);
    send_request(bfla_pkg::ACT_SEED, 1, 1'b1);
    send_request(bfla_pkg::ACT_SEED, 0, 1'b1);
    send_request(bfla_pkg::ACT_SEED, 4095, 1'b0);
    send_request(bfla_pkg::ACT_FREE, 0, 1'b0);
    send_request(ACT_UNKNOWN, 4095, 1'b1);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);

    // empty pool: free and seed out of range, allocate finds the list empty
    write_pool(0);
    send_request(bfla_pkg::ACT_FREE, 0, 1'b0);
    send_request(bfla_pkg::ACT_SEED, 5, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);

    // small pool, then shrink it below some of the listed blocks
    write_pool(10);
    send_request(bfla_pkg::ACT_FREE, 9, 1'b0);
    send_request(bfla_pkg::ACT_FREE, 10, 1'b0);
    send_request(bfla_pkg::ACT_SEED, 3, 1'b0);
    send_request(bfla_pkg::ACT_FREE, 1, 1'b0);
    write_pool(2);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);
    send_request(bfla_pkg::ACT_ALLOC, 0, 1'b0);

    // random phases over idle and stall mixes and pool sizes
    run_phase(4096, 0, 0, 400);
    run_phase(37, 65, 0, 400);
    run_phase($urandom_range(2, 200), 0, 65, 400);
    run_phase(1, 16, 16, 150);
    run_phase(64, 16, 16, 450);

    req.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("block_free_list_allocator test passed");
    else
      $display("block_free_list_allocator test failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/bfla_pkg.sv
rtl/core/bfla_ifs.sv
rtl/core/bfla_front.sv
rtl/core/bfla_queue.sv
rtl/core/bfla_back.sv
rtl/core/block_free_list_allocator.sv
test/block_free_list_allocator_checker.sv
test/block_free_list_allocator_test.sv
